/* hw/rtl/sha256_pkg.sv */
// SHA-256 hasher package: constants, round table and helper functions.
// No dependencies; used by every module of the hasher.
`default_nettype none
package sha256_pkg;

    localparam int WordW   = 32;
    localparam int CountW  = 61;
    localparam int RoundN  = 64;
    localparam int QueueN  = 4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef logic [WordW-1:0] word_t;

    // Block job handed from the packer to the compression engine.
    typedef struct packed {
        word_t [15:0] blk;
        logic         final_blk;
    } job_t;

    function automatic word_t init_hash(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        case (r)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha256_if.sv */
// Valid/ready channel interfaces for the hasher input and digest output.
// Depends on sha256_pkg.
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha256_out_if;
    logic                 valid;
    logic                 ready;
    sha256_pkg::word_t    digest_word;
    logic [2:0]           word_index;
    logic                 last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* hw/rtl/sha256_packer.sv */
// Front end: packs bytes into blocks, pads at end of message, emits block jobs.
// Depends on sha256_pkg.
`default_nettype none
module sha256_packer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               kind,
    input  wire logic [7:0]         data_byte,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output sha256_pkg::job_t        job
);

    typedef enum logic [1:0] {ST_BYTES, ST_PAD2, ST_WAIT} state_t;

    state_t                              state_reg, state_next;
    sha256_pkg::word_t [15:0]            blk_reg, blk_next;
    logic [sha256_pkg::CountW-1:0]       count_reg, count_next;
    logic                                jv_reg, jv_next;
    sha256_pkg::job_t                    job_reg, job_next;

    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [4:0]  sh;
    logic [63:0] bits;
    sha256_pkg::word_t [15:0] pad;
    sha256_pkg::word_t keep;

    assign pos  = count_reg[5:0];
    assign wi   = pos[5:2];
    assign sh   = 5'd24 - {pos[1:0], 3'b000};
    assign bits = {count_reg, 3'b000};
    assign in_ready  = (state_reg == ST_BYTES) && !jv_reg;
    assign job_valid = jv_reg;
    assign job       = job_reg;

    always_comb
    begin
        keep = blk_reg[wi] & ~((sha256_pkg::word_t'(1) << (sh + 5'd8)) - 1);
        if (pos[1:0] == 2'd0)
            keep = '0;
        pad = blk_reg;
        pad[wi] = keep | (sha256_pkg::word_t'(8'h80) << sh);
        for (int i = 0; i < 16; i++)
            if (4'(i) > wi)
                pad[i] = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        count_next = count_reg;
        jv_next    = jv_reg;
        job_next   = job_reg;
        if (jv_reg && job_ready)
            jv_next = 1'b0;
        case (state_reg)
            ST_BYTES:
            begin
                if (in_valid && in_ready)
                begin
                    if (kind == sha256_pkg::KIND_DATA)
                    begin
                        if (pos[1:0] == 2'd0)
                            blk_next[wi] = {data_byte, 24'h0};
                        else
                            blk_next[wi] = blk_reg[wi] |
                                           (sha256_pkg::word_t'(data_byte) << sh);
                        count_next = count_reg + 1'b1;
                        if (pos == 6'd63)
                        begin
                            job_next.blk       = blk_next;
                            job_next.final_blk = 1'b0;
                            jv_next            = 1'b1;
                        end
                    end
                    else
                    begin
                        job_next.blk = pad;
                        if (pos >= 6'd56)
                        begin
                            job_next.final_blk = 1'b0;
                            state_next         = ST_PAD2;
                        end
                        else
                        begin
                            job_next.blk[14]   = bits[63:32];
                            job_next.blk[15]   = bits[31:0];
                            job_next.final_blk = 1'b1;
                            count_next         = '0;
                        end
                        jv_next = 1'b1;
                    end
                end
            end
            ST_PAD2:
            begin
                if (!jv_next)
                begin
                    job_next.blk       = '0;
                    job_next.blk[14]   = bits[63:32];
                    job_next.blk[15]   = bits[31:0];
                    job_next.final_blk = 1'b1;
                    jv_next            = 1'b1;
                    count_next         = '0;
                    state_next         = ST_BYTES;
                end
            end
            default: state_next = ST_BYTES;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BYTES;
            count_reg <= '0;
            jv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            jv_reg    <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        job_reg <= job_next;
    end

    a_full_block_job: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == sha256_pkg::KIND_DATA && pos == 6'd63)
        |=> jv_reg) else $error("full block did not raise a job");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        jv_reg |-> !in_ready) else $error("byte taken with job pending");
    a_pad2_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD2 && jv_reg) |-> !job_reg.final_blk)
        else $error("overflow block marked final");

endmodule
`default_nettype wire

/* hw/rtl/sha256_job_queue.sv */
// Short queue of block jobs between packer and compression engine.
// Depends on sha256_pkg.
`default_nettype none
module sha256_job_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_valid,
    output logic              wr_ready,
    input  sha256_pkg::job_t  wr_job,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output sha256_pkg::job_t  rd_job
);

    localparam int PtrW = $clog2(sha256_pkg::QueueN);

    sha256_pkg::job_t       mem_reg [sha256_pkg::QueueN];
    logic [PtrW-1:0]        wp_reg, rp_reg;
    logic [PtrW:0]          cnt_reg;
    logic                   wr, rd;

    assign wr_ready = cnt_reg != (PtrW+1)'(sha256_pkg::QueueN);
    assign rd_valid = cnt_reg != '0;
    assign rd_job   = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(wr) - (PtrW+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(sha256_pkg::QueueN)) else $error("queue overflow");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count wrong");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> wp_reg == rp_reg) else $error("pointers disagree");

endmodule
`default_nettype wire

/* hw/rtl/sha256_engine.sv */
// Back end: one SHA-256 round per cycle, chaining update, digest word output.
// Depends on sha256_pkg.
`default_nettype none
module sha256_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    output logic                     job_ready,
    input  sha256_pkg::job_t         job,
    output logic                     dv,
    input  wire logic                dr,
    output sha256_pkg::word_t        dword,
    output logic [2:0]               didx,
    output logic                     dlast
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_OUT} state_t;
    typedef sha256_pkg::word_t word_t;

    state_t            state_reg;
    word_t [7:0]       h_reg;
    word_t [7:0]       v_reg;
    word_t [15:0]      w_reg;
    logic [5:0]        r_reg;
    logic              fin_reg;
    logic [2:0]        oi_reg;
    logic              dv_reg;
    word_t             dw_reg;

    word_t s0, s1, ch, mj, t1, t2, w, g0, g1;

    assign job_ready = state_reg == ST_IDLE;
    assign dv    = dv_reg;
    assign dword = dw_reg;
    assign didx  = oi_reg;
    assign dlast = oi_reg == 3'd7;

    // Schedule window kept as a shift line: w_reg[0] is this round's word.
    always_comb
    begin
        g0 = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        g1 = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        w  = w_reg[0];
        s1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
             ^ sha256_pkg::rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + sha256_pkg::round_k(r_reg) + w;
        s0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
             ^ sha256_pkg::rotr(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = s0 + mj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            r_reg     <= '0;
            oi_reg    <= '0;
            dv_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::init_hash(3'(i));
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        w_reg     <= job.blk;
                        v_reg     <= h_reg;
                        fin_reg   <= job.final_blk;
                        r_reg     <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= g1 + w_reg[9] + g0 + w_reg[0];
                    v_reg <= {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
                    r_reg <= r_reg + 1'b1;
                    if (r_reg == 6'd63)
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    oi_reg    <= '0;
                    state_reg <= fin_reg ? ST_OUT : ST_IDLE;
                end
                ST_OUT:
                begin
                    if (!dv_reg || dr)
                    begin
                        if (dv_reg && oi_reg == 3'd7)
                        begin
                            dv_reg    <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha256_pkg::init_hash(3'(i));
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            if (dv_reg)
                                oi_reg <= oi_reg + 1'b1;
                            dw_reg <= h_reg[dv_reg ? oi_reg + 3'd1 : oi_reg];
                            dv_reg <= 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> state_reg == ST_OUT) else $error("digest outside output phase");
    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && r_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("round count lost");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_reg && !dr) |=> dv_reg && $stable(dw_reg) && $stable(oi_reg))
        else $error("digest word changed while stalled");

endmodule
`default_nettype wire

/* hw/rtl/sha256_byte_hasher_unit.sv */
// SHA-256 byte hasher top level: packer, job queue and round engine.
// Depends on sha256_pkg, sha256_if and the three sub-modules.
//
// Message bytes arrive one per transfer (kind = data); a transfer with kind = end
// closes the message, and the block then returns the eight digest words, word 0
// first, last_word set on word 7. Bytes are taken one per cycle while no block job is
// pending; once a 64-byte block is complete, the packer holds that block until it moves
// into a four-entry job queue. The round engine runs one round per cycle; each block
// passes through a load, 64 rounds and a chaining add. With the queue in front,
// a continuous stream runs at about one byte per cycle, limited by the engine.
// An end transfer whose partial block holds 56 or more bytes costs two blocks.
// After the last digest word the chaining value returns to the initial hash.
`default_nettype none
module sha256_byte_hasher_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    sha256_in_if.sink           in_ch,
    sha256_out_if.source        out_ch
);

    logic               pj_valid, pj_ready, qj_valid, qj_ready;
    sha256_pkg::job_t   pj, qj;

    sha256_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .kind      (in_ch.kind),
        .data_byte (in_ch.data_byte),
        .job_valid (pj_valid),
        .job_ready (pj_ready),
        .job       (pj)
    );

    sha256_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (pj_valid),
        .wr_ready (pj_ready),
        .wr_job   (pj),
        .rd_valid (qj_valid),
        .rd_ready (qj_ready),
        .rd_job   (qj)
    );

    sha256_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qj_valid),
        .job_ready (qj_ready),
        .job       (qj),
        .dv        (out_ch.valid),
        .dr        (out_ch.ready),
        .dword     (out_ch.digest_word),
        .didx      (out_ch.word_index),
        .dlast     (out_ch.last_word)
    );

    a_last_is_seven: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 3'd7)))
        else $error("last_word flag mismatch");
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && !out_ch.last_word)
        |=> out_ch.word_index == $past(out_ch.word_index) + 3'd1)
        else $error("digest words out of order");
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> out_ch.word_index == 3'd0)
        else $error("digest does not start at word 0");

endmodule
`default_nettype wire
